FILE: sv/cti_pkg.sv
`default_nettype none

package cti_pkg;

    localparam int unsigned ANGLE_W = 32;
    localparam int unsigned COS_W   = 16;
    localparam int unsigned FRAC_W  = 16;

    // round(2^8 / (2*pi) * 2^24): radians in Q8.24 to turns in Q0.32, with a 2^24 shift
    localparam logic signed [ANGLE_W-1:0] TURN_SCALE   = 32'sd683565276;
    localparam logic [ANGLE_W-1:0]        QUARTER_TURN = 32'h4000_0000;
    localparam logic [63:0]               HALF_PI_Q30  = 64'd1686629713;

    localparam logic signed [COS_W-1:0] COS_MAX = 16'sd32767;
    localparam logic signed [COS_W-1:0] COS_MIN = -16'sd32767;

    // Sine of i / 2^log2_size turns in Q1.15, from a Q2.30 Taylor series.
    // Evaluated at elaboration only, to fill the sine table.
    function automatic logic signed [COS_W-1:0] sine_entry(
        input logic [31:0] i,
        input int unsigned log2_size
    );
        logic [31:0] p;
        logic [1:0]  q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] sum;
        logic [63:0] v;
        p = i << (32 - log2_size);
        q = p[31:30];
        r = {34'd0, p[29:0]};
        if (q[0])
        begin
            r = 64'h4000_0000 - r;
        end
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 64'd0;
        term = ((term * x2) >> 30) / 64'd6;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd20;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 64'd42;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd72;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 64'd110;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd156;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 64'd210;
        neg  = neg + term;
        sum  = (pos > neg) ? (pos - neg) : 64'd0;
        v    = (sum + 64'd16384) >> 15;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return q[1] ? (16'sd0 - signed'(v[COS_W-1:0])) : signed'(v[COS_W-1:0]);
    endfunction

endpackage

`default_nettype wire

FILE: sv/cti_angle_if.sv
`default_nettype none

interface cti_angle_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cti_pkg::ANGLE_W-1:0]   angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

`default_nettype wire

FILE: sv/cti_cosine_if.sv
`default_nettype none

interface cti_cosine_if;
    logic                               valid;
    logic                               ready;
    logic signed [cti_pkg::COS_W-1:0]   cosine;

    modport source (output valid, output cosine, input ready);
    modport sink   (input valid, input cosine, output ready);
endinterface

`default_nettype wire

FILE: sv/cos_table_interp.sv
`default_nettype none

// Channel     Modport  Payload                       Meaning
// angle_chan  sink     angle  [31:0] signed Q8.24    angle in radians
// cosine_chan source   cosine [15:0] signed Q1.15    cosine, saturated to +/-32767
//
// Five-stage pipeline, one transaction per cycle while cosine_chan is ready;
// a result is registered in each stage in turn before cosine_chan shows it.
// Stages: turn-scale multiply, phase add, sine table read (even/odd banks,
// one synchronous read each), interpolation multiply, round and clamp.
// Each stage advances when it is empty or its successor advances, so bubbles
// collapse and new angles keep entering while a result waits on the output.
// rst_n clears only the stage valid bits; the sine table is constant.
module cos_table_interp #(
    parameter int unsigned TABLE_SIZE = 512  // power of two, 16 to 4096
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cti_angle_if.sink     angle_chan,
    cti_cosine_if.source  cosine_chan
);

    localparam int unsigned IDX_W  = $clog2(TABLE_SIZE);
    localparam int unsigned HALF   = TABLE_SIZE / 2;
    localparam int unsigned FRAC_W = cti_pkg::FRAC_W;
    localparam int unsigned COS_W  = cti_pkg::COS_W;

    // ------------------------------------------------------------------
    // Sine table, split by entry parity so that the two neighbors of any
    // index fall into different banks. Even bank holds entries 0,2,..,N,
    // odd bank holds 1,3,..,N-1.
    // ------------------------------------------------------------------
    logic signed [COS_W-1:0] even_rom [0:HALF];
    logic signed [COS_W-1:0] odd_rom  [0:HALF-1];

    for (genvar gi = 0; gi <= HALF; gi++)
    begin : g_even
        localparam logic signed [COS_W-1:0] EntryVal =
            cti_pkg::sine_entry(32'(2 * gi), IDX_W);
        assign even_rom[gi] = EntryVal;
    end

    for (genvar gj = 0; gj < HALF; gj++)
    begin : g_odd
        localparam logic signed [COS_W-1:0] EntryVal =
            cti_pkg::sine_entry(32'(2 * gj + 1), IDX_W);
        assign odd_rom[gj] = EntryVal;
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or moves on.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic out_valid_reg;

    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;

    assign en5 = !out_valid_reg || cosine_chan.ready;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign angle_chan.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= angle_chan.valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en5)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: angle times 1/(2*pi). Keep product bits 55..23; bit 23 is
    // the rounding bit of the shift by 24.
    // ------------------------------------------------------------------
    logic signed [63:0] turn_prod;
    logic [32:0]        turn_reg;

    assign turn_prod = angle_chan.angle * cti_pkg::TURN_SCALE;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            turn_reg <= turn_prod[55:23];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: round, add a quarter turn (cos x = sin(x + pi/2)).
    // ------------------------------------------------------------------
    logic [31:0] phase_next;
    logic [31:0] phase_reg;

    assign phase_next = turn_reg[32:1] + 32'(turn_reg[0]) + cti_pkg::QUARTER_TURN;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            phase_reg <= phase_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: split phase into table index and Q0.16 fraction, read both
    // banks. For an even index the even bank gives the left entry; for an
    // odd index the even bank gives the right one.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  tbl_idx;
    logic [FRAC_W-1:0] tbl_frac;
    logic [IDX_W-1:0]  even_addr;
    logic [IDX_W-2:0]  odd_addr;

    assign tbl_idx   = phase_reg[31 -: IDX_W];
    assign tbl_frac  = phase_reg[31 - IDX_W -: FRAC_W];
    assign odd_addr  = tbl_idx[IDX_W-1:1];
    assign even_addr = IDX_W'(tbl_idx[IDX_W-1:1]) + IDX_W'(tbl_idx[0]);

    logic signed [COS_W-1:0] even_q_reg;
    logic signed [COS_W-1:0] odd_q_reg;
    logic [FRAC_W-1:0]       frac3_reg;
    logic                    odd3_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            even_q_reg <= even_rom[even_addr];
            odd_q_reg  <= odd_rom[odd_addr];
            frac3_reg  <= tbl_frac;
            odd3_reg   <= tbl_idx[0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: slope times fraction.
    // ------------------------------------------------------------------
    logic signed [COS_W-1:0]   left_val;
    logic signed [COS_W-1:0]   right_val;
    logic signed [COS_W:0]     slope;
    logic signed [2*COS_W+1:0] slope_prod;

    assign left_val   = odd3_reg ? odd_q_reg : even_q_reg;
    assign right_val  = odd3_reg ? even_q_reg : odd_q_reg;
    assign slope      = (COS_W+1)'(right_val) - (COS_W+1)'(left_val);
    assign slope_prod = slope * signed'({1'b0, frac3_reg});

    logic signed [2*COS_W+1:0] slope_prod_reg;
    logic signed [COS_W-1:0]   left4_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            slope_prod_reg <= slope_prod;
            left4_reg      <= left_val;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: add the base entry, round half up, clamp to +/-32767.
    // ------------------------------------------------------------------
    logic signed [2*COS_W+2:0] interp_acc;
    logic signed [COS_W+2:0]   interp_res;
    logic signed [COS_W-1:0]   cosine_next;
    logic signed [COS_W-1:0]   cosine_reg;

    assign interp_acc = (2*COS_W+3)'(signed'({left4_reg, 16'h0000}))
                      + (2*COS_W+3)'(slope_prod_reg)
                      + (2*COS_W+3)'(32768);
    assign interp_res = interp_acc[2*COS_W+2:16];

    always_comb
    begin
        if (interp_res > (COS_W+3)'(cti_pkg::COS_MAX))
        begin
            cosine_next = cti_pkg::COS_MAX;
        end
        else if (interp_res < (COS_W+3)'(cti_pkg::COS_MIN))
        begin
            cosine_next = cti_pkg::COS_MIN;
        end
        else
        begin
            cosine_next = interp_res[COS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            cosine_reg <= cosine_next;
        end
    end

    assign cosine_chan.valid  = out_valid_reg;
    assign cosine_chan.cosine = cosine_reg;

`ifndef NO_ASSERTIONS
    // Saturation keeps the most negative code off the output.
    a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> cosine_chan.cosine != 16'sh8000)
        else $error("cosine output carries the excluded code -32768");

    // An output that can move must never hold back the input.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        en5 |-> angle_chan.ready)
        else $error("input stalled while the output side can advance");

    // A stalled interpolation stage keeps its item and operands.
    a_stage4_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && !en4) |=> (s4_valid_reg && $stable(slope_prod_reg)
                                    && $stable(left4_reg)))
        else $error("interpolation stage lost its item during a stall");

    // Table read stage keeps its item while stalled.
    a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !en3) |=> (s3_valid_reg && $stable(frac3_reg)
                                    && $stable(even_q_reg) && $stable(odd_q_reg)))
        else $error("table read stage lost its item during a stall");
`endif

endmodule

`default_nettype wire
